@@ rtl/core/vrc_pkg.sv @@
// Package for the vector rotate CORDIC core: widths, constants, FSM state,
// controller/datapath command and status structs, arctangent table.
// No dependencies.
package vrc_pkg;

  localparam int unsigned AngleW     = 10;
  localparam int unsigned CoordW     = 8;
  localparam int unsigned AccW       = 18;
  localparam int unsigned PhaseW     = 12;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned MaxIter    = 8;
  localparam int unsigned Iterations = 8;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 16;

  localparam logic [AngleW-1:0]        AngleMask = 10'b1111111100;
  localparam logic signed [PhaseW-1:0] HalfPiQ7  = 12'sd201;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StReduce = 5'b00010,
    StIter   = 5'b00100,
    StGain   = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic reduce;
    logic iter;
    logic gain;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic a_ge_half;
    logic iter_last;
  } status_t;

  function automatic logic signed [PhaseW-1:0] atan_q7(input logic [IdxW-1:0] idx);
    logic signed [PhaseW-1:0] v;
    case (idx)
      3'd0:    v = 12'sh065;
      3'd1:    v = 12'sh03B;
      3'd2:    v = 12'sh01F;
      3'd3:    v = 12'sh010;
      3'd4:    v = 12'sh008;
      3'd5:    v = 12'sh004;
      3'd6:    v = 12'sh002;
      default: v = 12'sh001;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/vrc_ctrl.sv @@
// Controller FSM for the vector rotate CORDIC core: sequences reduce,
// micro-rotations, gain and output load. Depends on vrc_pkg.
module vrc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  vrc_pkg::status_t   status_i,
  output vrc_pkg::cmd_t      cmd_o
);

  vrc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      vrc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = vrc_pkg::StReduce;
        end
      end
      vrc_pkg::StReduce: begin
        if (status_i.a_ge_half) cmd_o.reduce = 1'b1;
        else                    state_d = vrc_pkg::StIter;
      end
      vrc_pkg::StIter: begin
        cmd_o.iter = 1'b1;
        if (status_i.iter_last) state_d = vrc_pkg::StGain;
      end
      vrc_pkg::StGain: begin
        cmd_o.gain = 1'b1;
        state_d    = vrc_pkg::StFinish;
      end
      vrc_pkg::StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = vrc_pkg::StIdle;
        end
      end
      default: state_d = vrc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrc_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/vrc_datapath.sv @@
// Datapath for the vector rotate CORDIC core: angle reduction, shared
// micro-rotation unit, gain correction, quadrant fix, output register.
// Depends on vrc_pkg.
module vrc_datapath #(
  parameter int unsigned ITERATIONS = vrc_pkg::Iterations
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [vrc_pkg::AngleW-1:0]         angle_q7_i,
  input  logic signed [vrc_pkg::CoordW-1:0]  x_in_i,
  input  logic signed [vrc_pkg::CoordW-1:0]  y_in_i,
  input  vrc_pkg::cmd_t                      cmd_i,
  output vrc_pkg::status_t                   status_o,
  output logic signed [vrc_pkg::CoordW-1:0]  x_out_o,
  output logic signed [vrc_pkg::CoordW-1:0]  y_out_o
);

  localparam int unsigned AccW = vrc_pkg::AccW;

  logic signed [vrc_pkg::PhaseW-1:0] a_q;
  logic signed [AccW-1:0]            x_q, y_q;
  logic [1:0]                        quad_q;
  logic [vrc_pkg::IdxW-1:0]          cnt_q;
  logic signed [vrc_pkg::CoordW-1:0] xo_q, yo_q;

  logic signed [AccW-1:0]            sx, sy, xg, yg, rx, ry;
  logic signed [vrc_pkg::PhaseW-1:0] at;

  // reset only on the iteration counter; payload needs none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.iter) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sx = x_q >>> cnt_q;
  assign sy = y_q >>> cnt_q;
  assign at = vrc_pkg::atan_q7(cnt_q);

  // gain 0.609375 then scale back by 2^-7
  assign xg = ((x_q >>> 6) + (x_q >>> 5) + (x_q >>> 4) + (x_q >>> 1)) >>> 7;
  assign yg = ((y_q >>> 6) + (y_q >>> 5) + (y_q >>> 4) + (y_q >>> 1)) >>> 7;

  always_comb begin
    case (quad_q)
      2'd0:    begin rx = x_q;  ry = y_q;  end
      2'd1:    begin rx = -y_q; ry = x_q;  end
      2'd2:    begin rx = -x_q; ry = -y_q; end
      default: begin rx = y_q;  ry = -x_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= vrc_pkg::PhaseW'({2'b00, angle_q7_i & vrc_pkg::AngleMask});
      x_q    <= AccW'(x_in_i) <<< 7;
      y_q    <= AccW'(y_in_i) <<< 7;
      quad_q <= 2'd0;
    end else if (cmd_i.reduce) begin
      a_q    <= a_q - vrc_pkg::HalfPiQ7;
      quad_q <= quad_q + 2'd1;
    end else if (cmd_i.iter) begin
      if (!a_q[vrc_pkg::PhaseW-1]) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        a_q <= a_q - at;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        a_q <= a_q + at;
      end
    end else if (cmd_i.gain) begin
      x_q <= xg;
      y_q <= yg;
    end
    if (cmd_i.out_load) begin
      xo_q <= rx[vrc_pkg::CoordW-1:0];
      yo_q <= ry[vrc_pkg::CoordW-1:0];
    end
  end

  assign status_o.a_ge_half = (a_q >= vrc_pkg::HalfPiQ7);
  assign status_o.iter_last = (cnt_q == vrc_pkg::IdxW'(ITERATIONS - 1));
  assign x_out_o = xo_q;
  assign y_out_o = yo_q;

endmodule

@@ rtl/core/vector_rotate_cordic_core.sv @@
// Vector rotate CORDIC core: rotates a signed 8-bit point by a Q7 angle
// (angle bits 1:0 ignored). One word at a time: after a word is accepted the
// block runs angle reduction (k = 0..5 subtractions of pi/2), ITERATIONS
// micro-rotations on the shared micro-rotation unit, gain correction and the
// load of the output register (held off while a stalled result waits); it
// then returns to idle before it accepts the next input word.
// The result word waits in the output register while the next word runs.
// Top level; depends on vrc_pkg, vrc_ctrl, vrc_datapath.
module vector_rotate_cordic_core #(
  parameter int unsigned ITERATIONS = vrc_pkg::Iterations
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // [9:0] angle_q7, [17:10] x_in, [25:18] y_in, [31:26] zero
  input  logic [vrc_pkg::InDataW-1:0]   s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [7:0] x_out, [15:8] y_out
  output logic [vrc_pkg::OutDataW-1:0]  m_tdata_o
);

  vrc_pkg::cmd_t    cmd;
  vrc_pkg::status_t status;
  logic signed [vrc_pkg::CoordW-1:0] x_out, y_out;

  vrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vrc_datapath #(
    .ITERATIONS (ITERATIONS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .angle_q7_i (s_tdata_i[9:0]),
    .x_in_i     (s_tdata_i[17:10]),
    .y_in_i     (s_tdata_i[25:18]),
    .cmd_i      (cmd),
    .status_o   (status),
    .x_out_o    (x_out),
    .y_out_o    (y_out)
  );

  assign m_tdata_o = {y_out, x_out};

endmodule

@@ rtl/core/vrc_checker.sv @@
// Port-level assertions for the vector rotate CORDIC core, bound to the top.
// Depends on vrc_pkg and vector_rotate_cordic_core.
module vrc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_tvalid_i,
  input logic                         s_tready_o,
  input logic                         m_tvalid_o,
  input logic                         m_tready_i,
  input logic [vrc_pkg::OutDataW-1:0] m_tdata_o
);

  // one word in flight: busy right after accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input ready right after accept");

  // minimum latency: no new result the cycle after accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !$rose(m_tvalid_o))
    else $error("result too early");

  // a new result leaves the core idle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> s_tready_o)
    else $error("result raised while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("stalled output changed");

endmodule

bind vector_rotate_cordic_core vrc_checker u_vrc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

@@ tb/testbench.sv @@
// Testbench for vector_rotate_cordic_core: directed table, then random words
// under three sender/receiver idle mixes; results checked against a predictor
// or a typed row's stored result. Depends on vrc_pkg and the RTL of the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned PhaseWords    = 483;
  localparam int unsigned DirectedRows  = 22;

  typedef struct packed {
    logic signed [vrc_pkg::CoordW-1:0] y;
    logic signed [vrc_pkg::CoordW-1:0] x;
  } point_t;

  typedef struct {
    logic [vrc_pkg::AngleW-1:0]        angle;
    logic signed [vrc_pkg::CoordW-1:0] x;
    logic signed [vrc_pkg::CoordW-1:0] y;
    bit                                typed;
    point_t                            result;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni     = 1'b0;
  logic                          s_tvalid_i = 1'b0;
  logic                          s_tready_o;
  // [9:0] angle_q7, [17:10] x_in, [25:18] y_in, [31:26] zero
  logic [vrc_pkg::InDataW-1:0]   s_tdata_i  = '0;
  logic                          m_tvalid_o;
  logic                          m_tready_i = 1'b0;
  // [7:0] x_out, [15:8] y_out
  logic [vrc_pkg::OutDataW-1:0]  m_tdata_o;

  point_t      rotation_expected [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 26;
  int unsigned recv_idle_pct  = 65;
  int unsigned phase_idx      = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  int AtanTab [8] = '{101, 59, 31, 16, 8, 4, 2, 1};

  dir_row_t directed_rows [DirectedRows] = '{
    '{10'd0,    8'sd0,    8'sd0,    1'b1, '{8'sd0, 8'sd0}},
    '{10'd1023, 8'sd0,    8'sd0,    1'b1, '{8'sd0, 8'sd0}},
    '{10'd1005, 8'sd0,    8'sd0,    1'b1, '{8'sd0, 8'sd0}},
    '{10'd0,    8'sd127,  8'sd0,    1'b0, '0},
    '{10'd3,    8'sd127,  8'sd0,    1'b0, '0},
    '{10'd4,    -8'sd128, 8'sd127,  1'b0, '0},
    '{10'd100,  8'sd127,  8'sd127,  1'b0, '0},
    '{10'd100,  -8'sd128, -8'sd128, 1'b0, '0},
    '{10'd200,  8'sd127,  -8'sd128, 1'b0, '0},
    '{10'd201,  8'sd127,  8'sd0,    1'b0, '0},
    '{10'd202,  8'sd0,    8'sd127,  1'b0, '0},
    '{10'd301,  -8'sd128, 8'sd127,  1'b0, '0},
    '{10'd402,  8'sd127,  8'sd127,  1'b0, '0},
    '{10'd603,  -8'sd128, -8'sd128, 1'b0, '0},
    '{10'd700,  8'sd1,    8'sd0,    1'b0, '0},
    '{10'd804,  -8'sd1,   -8'sd1,   1'b0, '0},
    '{10'd1004, 8'sd127,  8'sd0,    1'b0, '0},
    '{10'd1005, 8'sd127,  8'sd0,    1'b0, '0},
    '{10'd1008, -8'sd128, 8'sd127,  1'b0, '0},
    '{10'd1020, 8'sd127,  8'sd127,  1'b0, '0},
    '{10'd1023, -8'sd128, -8'sd128, 1'b0, '0},
    '{10'd1023, 8'sd85,   -8'sd86,  1'b0, '0}
  };

  vector_rotate_cordic_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic point_t rotate_point(input logic [vrc_pkg::InDataW-1:0] w);
    int          a;
    int          x;
    int          y;
    int          sx;
    int          sy;
    int          rx;
    int          ry;
    logic [1:0]  quad;
    point_t      p;
    a = int'(w[vrc_pkg::AngleW-1:0] & vrc_pkg::AngleMask);
    x = int'($signed(w[vrc_pkg::AngleW +: vrc_pkg::CoordW]));
    y = int'($signed(w[vrc_pkg::AngleW+vrc_pkg::CoordW +: vrc_pkg::CoordW]));
    x = x * 128;
    y = y * 128;
    quad = 2'd0;
    while (a >= 201) begin
      a = a - 201;
      quad = quad + 2'd1;
    end
    for (int i = 0; i < int'(vrc_pkg::Iterations) && i < 8; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (a >= 0) begin
        x = x - sy;
        y = y + sx;
        a = a - AtanTab[i];
      end else begin
        x = x + sy;
        y = y - sx;
        a = a + AtanTab[i];
      end
    end
    x = ((x >>> 6) + (x >>> 5) + (x >>> 4) + (x >>> 1)) >>> 7;
    y = ((y >>> 6) + (y >>> 5) + (y >>> 4) + (y >>> 1)) >>> 7;
    case (quad)
      2'd0: begin rx = x;  ry = y;  end
      2'd1: begin rx = -y; ry = x;  end
      2'd2: begin rx = -x; ry = -y; end
      default: begin rx = y; ry = -x; end
    endcase
    p.x = rx[vrc_pkg::CoordW-1:0];
    p.y = ry[vrc_pkg::CoordW-1:0];
    return p;
  endfunction

  function automatic logic signed [vrc_pkg::CoordW-1:0] random_coord();
    logic signed [vrc_pkg::CoordW-1:0] v;
    case ($urandom_range(15))
      0:       v = 8'sd127;
      1:       v = -8'sd128;
      2:       v = 8'sd0;
      3:       v = -8'sd1;
      default: v = vrc_pkg::CoordW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_word(input logic [vrc_pkg::InDataW-1:0] w, input bit typed,
                           input point_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= w;
    do @(posedge clk_i); while (!s_tready_o);
    rotation_expected.push_back(typed ? res : rotate_point(w));
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    logic [vrc_pkg::InDataW-1:0] w;
    for (int unsigned n = 0; n < count; n++) begin
      w = '0;
      w[vrc_pkg::AngleW-1:0] = vrc_pkg::AngleW'($urandom_range(1023));
      w[vrc_pkg::AngleW +: vrc_pkg::CoordW] = random_coord();
      w[vrc_pkg::AngleW+vrc_pkg::CoordW +: vrc_pkg::CoordW] = random_coord();
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    logic [vrc_pkg::InDataW-1:0] w;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[r]) begin
      w = '0;
      w[vrc_pkg::AngleW-1:0] = directed_rows[r].angle;
      w[vrc_pkg::AngleW +: vrc_pkg::CoordW] = directed_rows[r].x;
      w[vrc_pkg::AngleW+vrc_pkg::CoordW +: vrc_pkg::CoordW] = directed_rows[r].y;
      send_word(w, directed_rows[r].typed, directed_rows[r].result);
    end
    send_random(PhaseWords);
    phase_idx     = 1;
    send_idle_pct = 65;
    recv_idle_pct = 26;
    send_random(PhaseWords);
    phase_idx     = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(PhaseWords + 1);
    s_tvalid_i <= 1'b0;
    while (rotation_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && rotation_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver ready, with one long hold-off in the no-idle phase
  always @(negedge clk_i) begin
    if (!hold_done && phase_idx == 2) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    point_t got;
    point_t want;
    if (m_tvalid_o && m_tready_i) begin
      got = m_tdata_o;
      if (rotation_expected.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d", $time, got.x, got.y);
        mismatch_count++;
      end else begin
        want = rotation_expected.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: x_out expected %0d actual %0d", $time, want.x, got.x);
          mismatch_count++;
        end
        if (got.y !== want.y) begin
          $display("%0t: y_out expected %0d actual %0d", $time, want.y, got.y);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
